[rtl/oli_pkg.sv]
// shared types and constants for the ordered list block
package oli_pkg;

    // field widths
    localparam int ELEM_W     = 30;
    localparam int POS_W      = 8;
    localparam int CMD_W      = 2;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_USER_W = 2;

    // bit places of the flags in the output tuser
    localparam int USER_EMPTY_BIT   = 0;
    localparam int USER_DROPPED_BIT = 1;

    // command codes carried in the input tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_BACK  = 2'd1,
        CMD_DELETE     = 2'd2,
        CMD_NOP        = 2'd3
    } t_cmd;

endpackage

[rtl/oli_mem.sv]
// element store: one write port, one read port with registered read data
module oli_mem #(
    parameter int DEPTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]     i_wr_addr,
    input  logic [oli_pkg::ELEM_W-1:0]   i_wr_data,
    input  logic                         i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]     i_rd_addr,
    output logic [oli_pkg::ELEM_W-1:0]   o_rd_data
);

    logic [oli_pkg::ELEM_W-1:0] r_mem [DEPTH];
    logic [oli_pkg::ELEM_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/ordered_list_insert_delete.sv]
// top level: ordered list with insert at front or back and delete at position
//
// Keeps up to DEPTH values in order in a single-port-write, single-port-read
// store. One command is taken at a time; s_axis_tready is high only while the
// block is idle. An insert at the back writes in the accept cycle. An insert at
// the front moves every stored value up one place through the store's read and
// write ports, one value per cycle, then a drain state lands the last move and
// a fill state writes the new value at the front. A delete at position p moves
// the values above p down one place through the move and drain states. After
// that the whole list is read out front to back at one item per cycle while
// m_axis_tready is high; each item passes through the store's registered read
// data before the output register, and the last item is flagged by tlast. An
// empty list gives one item with the empty flag. An insert into a full list is
// dropped and flagged on every item.
module ordered_list_insert_delete #(
    parameter int DEPTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // command channel
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // tdata: value [29:0], position [37:30], zero [39:38]
    input  logic [oli_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // tuser: cmd [1:0]
    input  logic [oli_pkg::CMD_W-1:0]       i_s_axis_tuser,
    // result channel
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // tdata: element [29:0], zero [31:30]
    output logic [oli_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    output logic                            o_m_axis_tlast,
    // tuser: list_empty [0], dropped [1]
    output logic [oli_pkg::OUT_USER_W-1:0]  o_m_axis_tuser
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOVE,
        ST_DRAIN,
        ST_FILL,
        ST_OUT
    } t_state;

    // sequencer state
    t_state                      r_state, n_state;
    logic [CW-1:0]               r_count, n_count;
    logic [CW-1:0]               r_src, n_src;
    logic [CW-1:0]               r_left, n_left;
    logic                        r_dir_up, n_dir_up;
    logic                        r_wr_pend, n_wr_pend;
    logic [AW-1:0]               r_wr_addr, n_wr_addr;
    logic [oli_pkg::ELEM_W-1:0]  r_val, n_val;
    logic                        r_drop, n_drop;
    logic [CW-1:0]               r_k, n_k;
    logic                        r_rd_vld, n_rd_vld;
    logic                        r_rd_last, n_rd_last;
    // output register
    logic                        r_o_valid, n_o_valid;
    logic [oli_pkg::ELEM_W-1:0]  r_o_elem, n_o_elem;
    logic                        r_o_last, n_o_last;
    logic                        r_o_empty, n_o_empty;
    logic                        r_o_drop, n_o_drop;

    // store port signals
    logic                        mem_wr_en;
    logic [AW-1:0]               mem_wr_addr;
    logic [oli_pkg::ELEM_W-1:0]  mem_wr_data;
    logic                        mem_rd_en;
    logic [AW-1:0]               mem_rd_addr;
    logic [oli_pkg::ELEM_W-1:0]  mem_rd_data;

    // input fields
    oli_pkg::t_cmd               in_cmd;
    logic [oli_pkg::ELEM_W-1:0]  in_value;
    logic [oli_pkg::POS_W-1:0]   in_pos;
    logic [oli_pkg::POS_W-1:0]   count_ext;
    logic [oli_pkg::POS_W-1:0]   del_moves;
    logic                        full;
    logic                        out_free;
    logic                        consume;
    logic                        issue;

    assign in_cmd    = oli_pkg::t_cmd'(i_s_axis_tuser);
    assign in_value  = i_s_axis_tdata[oli_pkg::ELEM_W-1:0];
    assign in_pos    = i_s_axis_tdata[oli_pkg::ELEM_W +: oli_pkg::POS_W];
    assign count_ext = oli_pkg::POS_W'(r_count);
    assign del_moves = count_ext - in_pos - oli_pkg::POS_W'(1);
    assign full      = (r_count == CW'(DEPTH));
    assign out_free  = !r_o_valid || i_m_axis_tready;
    assign consume   = (r_state == ST_OUT) && r_rd_vld && out_free;
    assign issue     = (r_state == ST_OUT) && (r_k < r_count) && (!r_rd_vld || consume);

    oli_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    // sequencer and store port control
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_src       = r_src;
        n_left      = r_left;
        n_dir_up    = r_dir_up;
        n_wr_pend   = 1'b0;
        n_wr_addr   = r_wr_addr;
        n_val       = r_val;
        n_drop      = r_drop;
        n_k         = '0;
        n_rd_vld    = r_rd_vld;
        n_rd_last   = r_rd_last;
        n_o_valid   = r_o_valid && !i_m_axis_tready;
        n_o_elem    = r_o_elem;
        n_o_last    = r_o_last;
        n_o_empty   = r_o_empty;
        n_o_drop    = r_o_drop;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_wr_addr;
        mem_wr_data = mem_rd_data;
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_src[AW-1:0];

        // a pending move lands in the cycle after its read
        if (r_wr_pend) begin
            mem_wr_en = 1'b1;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_drop  = 1'b0;
                    n_state = ST_OUT;
                    case (in_cmd)
                        oli_pkg::CMD_PUSH_FRONT: begin
                            if (full) begin
                                n_drop = 1'b1;
                            end else if (r_count == '0) begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = '0;
                                mem_wr_data = in_value;
                                n_count     = r_count + CW'(1);
                            end else begin
                                n_val    = in_value;
                                n_src    = r_count - CW'(1);
                                n_left   = r_count;
                                n_dir_up = 1'b1;
                                n_count  = r_count + CW'(1);
                                n_state  = ST_MOVE;
                            end
                        end
                        oli_pkg::CMD_PUSH_BACK: begin
                            if (full) begin
                                n_drop = 1'b1;
                            end else begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = r_count[AW-1:0];
                                mem_wr_data = in_value;
                                n_count     = r_count + CW'(1);
                            end
                        end
                        oli_pkg::CMD_DELETE: begin
                            if (count_ext > in_pos) begin
                                n_count = r_count - CW'(1);
                                if (del_moves != '0) begin
                                    n_src    = CW'(in_pos + oli_pkg::POS_W'(1));
                                    n_left   = CW'(del_moves);
                                    n_dir_up = 1'b0;
                                    n_state  = ST_MOVE;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_MOVE: begin
                // read one value, write it one place over next cycle
                mem_rd_en   = 1'b1;
                mem_rd_addr = r_src[AW-1:0];
                n_wr_pend   = 1'b1;
                if (r_dir_up) begin
                    n_wr_addr = AW'(r_src + CW'(1));
                    n_src     = r_src - CW'(1);
                end else begin
                    n_wr_addr = AW'(r_src - CW'(1));
                    n_src     = r_src + CW'(1);
                end
                n_left = r_left - CW'(1);
                if (r_left == CW'(1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = r_dir_up ? ST_FILL : ST_OUT;
            end
            ST_FILL: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = '0;
                mem_wr_data = r_val;
                n_state     = ST_OUT;
            end
            ST_OUT: begin
                n_k = r_k;
                if (r_count == '0) begin
                    // empty list gives one flagged item
                    if (out_free) begin
                        n_o_valid = 1'b1;
                        n_o_elem  = '0;
                        n_o_last  = 1'b1;
                        n_o_empty = 1'b1;
                        n_o_drop  = r_drop;
                        n_state   = ST_IDLE;
                    end
                end else begin
                    if (consume) begin
                        n_o_valid = 1'b1;
                        n_o_elem  = mem_rd_data;
                        n_o_last  = r_rd_last;
                        n_o_empty = 1'b0;
                        n_o_drop  = r_drop;
                        n_rd_vld  = 1'b0;
                        if (r_k == r_count) begin
                            n_state = ST_IDLE;
                        end
                    end
                    if (issue) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = r_k[AW-1:0];
                        n_rd_vld    = 1'b1;
                        n_rd_last   = (r_k + CW'(1) == r_count);
                        n_k         = r_k + CW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_wr_pend <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_o_valid <= 1'b0;
            r_k       <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_wr_pend <= n_wr_pend;
            r_rd_vld  <= n_rd_vld;
            r_o_valid <= n_o_valid;
            r_k       <= n_k;
        end
        r_src     <= n_src;
        r_left    <= n_left;
        r_dir_up  <= n_dir_up;
        r_wr_addr <= n_wr_addr;
        r_val     <= n_val;
        r_drop    <= n_drop;
        r_rd_last <= n_rd_last;
        r_o_elem  <= n_o_elem;
        r_o_last  <= n_o_last;
        r_o_empty <= n_o_empty;
        r_o_drop  <= n_o_drop;
    end

    // port drive
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = oli_pkg::OUT_DATA_W'(r_o_elem);
    assign o_m_axis_tlast  = r_o_last;
    assign o_m_axis_tuser[oli_pkg::USER_EMPTY_BIT]   = r_o_empty;
    assign o_m_axis_tuser[oli_pkg::USER_DROPPED_BIT] = r_o_drop;

`ifndef SYNTHESIS
    // list never holds more than the store
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("count above depth");

    // count moves only on an accepted command
    a_count_only_on_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_s_axis_tvalid && o_s_axis_tready) |=> $stable(r_count))
        else $error("count changed without a command");

    // prefetched value exists only during readout
    a_prefetch_in_readout : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> r_state == ST_OUT)
        else $error("read data pending outside readout");

    // a move phase always has work left
    a_move_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_MOVE |-> r_left != '0)
        else $error("move phase with nothing to move");

    // an empty-list item is the last and carries zero
    a_empty_item : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && r_o_empty |-> o_m_axis_tlast && r_o_elem == '0)
        else $error("bad empty-list item");
`endif

endmodule
